@@ hdl/deq_pkg.sv @@
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } deq_state_t;

    typedef enum logic [1:0] {
        PEND_READ,
        PEND_POP_FRONT,
        PEND_POP_BACK
    } deq_pend_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [7:0]         position;
    } deq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_word;
        logic signed [31:0] front_word;
        logic signed [31:0] back_word;
        logic [8:0]         count;
    } deq_rsp_t;

endpackage

`default_nettype wire

@@ hdl/double_ended_queue_top.sv @@
// Double-ended queue of signed words on a ring buffer with one synchronous memory.
//
// One item is in flight at a time. Pushes, rejected operations, unused codes and a
// pop that empties the queue give their result at the edge the item is accepted;
// a read and a pop that leaves words behind pass through the wait state, as the
// store memory has a registered read (the read fetches the new front or back word).
// The front and back words are held in registers so every result carries them.
// The result sits in an output register, so the next item is taken in the same
// cycle the previous result is taken. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top #(
    parameter int CAPACITY = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire deq_pkg::deq_req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output deq_pkg::deq_rsp_t    rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int SW = ((AW > 8) ? AW : 8) + 1;

    logic signed [31:0] mem [CAPACITY];

    deq_pkg::deq_state_t state_reg, state_next;
    deq_pkg::deq_pend_t  pend_reg, pend_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic signed [31:0]  front_reg, front_next;
    logic signed [31:0]  back_reg, back_next;
    logic                out_valid_reg, out_valid_next;
    deq_pkg::deq_rsp_t   out_reg, out_next;
    logic                out_load;
    logic signed [31:0]  rd_data_reg;

    logic                accept;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                is_full;
    logic                is_empty;

    // Ring slot at base + offset, offset below twice the capacity after the base
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [SW-1:0] offset);
        logic [SW-1:0] sum;
        begin
            sum = SW'(base) + offset;
            if (sum >= SW'(CAPACITY))
            begin
                sum = sum - SW'(CAPACITY);
            end
            slot_add = sum[AW-1:0];
        end
    endfunction

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == deq_pkg::ST_IDLE) && (!out_valid_reg || rsp_ready);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign is_full   = (fill_reg == FW'(CAPACITY));
    assign is_empty  = (fill_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        front_next = front_reg;
        back_next  = back_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        out_load   = 1'b0;
        out_next   = out_reg;

        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_load           = 1'b1;
                    out_next.status    = deq_pkg::STATUS_DONE;
                    out_next.read_word = '0;
                    case (req.operation)
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                out_next.status = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + FW'(1);
                                if (req.operation == deq_pkg::OP_PUSH_FRONT)
                                begin
                                    head_next  = (head_reg == '0) ? AW'(CAPACITY - 1)
                                                                  : head_reg - AW'(1);
                                    wr_addr    = head_next;
                                    front_next = req.value;
                                    if (is_empty)
                                    begin
                                        back_next = req.value;
                                    end
                                end
                                else
                                begin
                                    wr_addr   = slot_add(head_reg, SW'(fill_reg));
                                    back_next = req.value;
                                    if (is_empty)
                                    begin
                                        front_next = req.value;
                                    end
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_next.status = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - FW'(1);
                                if (req.operation == deq_pkg::OP_POP_FRONT)
                                begin
                                    head_next = slot_add(head_reg, SW'(1));
                                end
                                if (fill_reg == FW'(1))
                                begin
                                    front_next = '0;
                                    back_next  = '0;
                                end
                                else
                                begin
                                    // fetch the word that becomes the new end
                                    out_load   = 1'b0;
                                    rd_en      = 1'b1;
                                    state_next = deq_pkg::ST_WAIT;
                                    if (req.operation == deq_pkg::OP_POP_FRONT)
                                    begin
                                        rd_addr   = slot_add(head_reg, SW'(1));
                                        pend_next = deq_pkg::PEND_POP_FRONT;
                                    end
                                    else
                                    begin
                                        rd_addr   = slot_add(head_reg,
                                                             SW'(fill_reg) - SW'(2));
                                        pend_next = deq_pkg::PEND_POP_BACK;
                                    end
                                end
                            end
                        end
                        deq_pkg::OP_READ:
                        begin
                            if (SW'(req.position) >= SW'(fill_reg))
                            begin
                                out_next.status = deq_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                out_load   = 1'b0;
                                rd_en      = 1'b1;
                                rd_addr    = slot_add(head_reg, SW'(req.position));
                                pend_next  = deq_pkg::PEND_READ;
                                state_next = deq_pkg::ST_WAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_next.front_word = front_next;
                    out_next.back_word  = back_next;
                    out_next.count      = 9'(fill_next);
                end
            end
            deq_pkg::ST_WAIT:
            begin
                out_load           = 1'b1;
                out_next.status    = deq_pkg::STATUS_DONE;
                out_next.read_word = '0;
                case (pend_reg)
                    deq_pkg::PEND_READ:      out_next.read_word = rd_data_reg;
                    deq_pkg::PEND_POP_FRONT: front_next = rd_data_reg;
                    deq_pkg::PEND_POP_BACK:  back_next = rd_data_reg;
                    default:
                    begin
                    end
                endcase
                out_next.front_word = front_next;
                out_next.back_word  = back_next;
                out_next.count      = 9'(fill_reg);
                state_next          = deq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::ST_IDLE;
            pend_reg      <= deq_pkg::PEND_READ;
            head_reg      <= '0;
            fill_reg      <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until the next one is loaded
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ test/double_ended_queue_top_tb.sv @@
// Self-checking testbench for the double-ended queue: directed table, then random push/pop phases.
`timescale 1ns / 1ps

module double_ended_queue_top_tb;

    localparam int DEPTH          = 256;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1425;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [2:0] OP_UNUSED_5 = 3'd5;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } load_phase_t;

    typedef struct {
        deq_pkg::deq_req_t item;
        logic              typed;
        deq_pkg::deq_rsp_t want;
    } directed_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    deq_pkg::deq_req_t req;
    logic              rsp_valid;
    logic              rsp_ready;
    deq_pkg::deq_rsp_t rsp;

    // Expected result typed in the directed table, held alongside the payload
    logic              cur_typed;
    deq_pkg::deq_rsp_t cur_want;
    logic              quiet_stretch;

    logic signed [31:0] mirror_words [DEPTH];
    logic [7:0]         mirror_head = '0;
    logic [8:0]         mirror_fill = '0;

    deq_pkg::deq_rsp_t owed_results [$];
    directed_row_t     directed_rows [$];
    int                mismatches  = 0;
    int                idle_cycles = 0;

    double_ended_queue_top #(
        .CAPACITY(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    function automatic deq_pkg::deq_rsp_t rsp_of(input logic [1:0] status,
                                                 input logic signed [31:0] rd,
                                                 input logic signed [31:0] front,
                                                 input logic signed [31:0] back,
                                                 input logic [8:0] count);
        deq_pkg::deq_rsp_t r;
        r.status     = status;
        r.read_word  = rd;
        r.front_word = front;
        r.back_word  = back;
        r.count      = count;
        return r;
    endfunction

    // Apply one operation to the mirrored ring and return the result it should give
    function automatic deq_pkg::deq_rsp_t advance_deque(input deq_pkg::deq_req_t item);
        deq_pkg::deq_rsp_t r;
        logic [7:0]        slot;
        r = '0;
        r.status = deq_pkg::STATUS_DONE;
        case (item.operation)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
            begin
                if (mirror_fill == DEPTH)
                begin
                    r.status = deq_pkg::STATUS_FULL;
                end
                else if (item.operation == deq_pkg::OP_PUSH_FRONT)
                begin
                    mirror_head = mirror_head - 8'd1;
                    mirror_words[mirror_head] = item.value;
                    mirror_fill = mirror_fill + 9'd1;
                end
                else
                begin
                    slot = mirror_head + mirror_fill[7:0];
                    mirror_words[slot] = item.value;
                    mirror_fill = mirror_fill + 9'd1;
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
            begin
                if (mirror_fill == 0)
                begin
                    r.status = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    if (item.operation == deq_pkg::OP_POP_FRONT)
                    begin
                        mirror_head = mirror_head + 8'd1;
                    end
                    mirror_fill = mirror_fill - 9'd1;
                end
            end
            deq_pkg::OP_READ:
            begin
                if ({1'b0, item.position} >= mirror_fill)
                begin
                    r.status = deq_pkg::STATUS_RANGE;
                end
                else
                begin
                    slot = mirror_head + item.position;
                    r.read_word = mirror_words[slot];
                end
            end
            default:
            begin
            end
        endcase
        if (mirror_fill != 0)
        begin
            r.front_word = mirror_words[mirror_head];
            slot = mirror_head + mirror_fill[7:0] - 8'd1;
            r.back_word = mirror_words[slot];
        end
        r.count = mirror_fill;
        return r;
    endfunction

    function automatic deq_pkg::deq_req_t random_item(input load_phase_t phase);
        deq_pkg::deq_req_t item;
        int                pick;
        int                push_pct;
        int                pop_pct;
        int                read_pct;
        item.value    = $urandom;
        item.position = 8'($urandom_range(255));
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(3))
                0: item.value = WORD_MAX;
                1: item.value = WORD_MIN;
                2: item.value = '0;
                default: item.value = '1;
            endcase
        end
        case (phase)
            PH_FILL:  begin push_pct = 88; pop_pct = 4;  read_pct = 6;  end
            PH_DRAIN: begin push_pct = 4;  pop_pct = 88; read_pct = 6;  end
            default:  begin push_pct = 35; pop_pct = 35; read_pct = 25; end
        endcase
        pick = $urandom_range(99);
        if (pick < push_pct)
        begin
            item.operation = $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        end
        else if (pick < push_pct + pop_pct)
        begin
            item.operation = $urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
        end
        else if (pick < push_pct + pop_pct + read_pct)
        begin
            item.operation = deq_pkg::OP_READ;
            // Aim most reads inside the stored words
            if (mirror_fill != 0 && $urandom_range(3) != 0)
            begin
                item.position = 8'($urandom_range(mirror_fill - 1));
            end
        end
        else
        begin
            item.operation = 3'($urandom_range(OP_UNUSED_7, OP_UNUSED_5));
        end
        return item;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic signed [31:0] value,
                           input logic [7:0] position, input logic typed,
                           input deq_pkg::deq_rsp_t want);
        directed_row_t row;
        row.item.operation = op;
        row.item.value     = value;
        row.item.position  = position;
        row.typed          = typed;
        row.want           = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Enter and leave at a falling edge; idle at random unless in the quiet stretch
    task automatic send_item(input deq_pkg::deq_req_t item, input logic typed,
                             input deq_pkg::deq_rsp_t want);
        while (!quiet_stretch && $urandom_range(99) < 20)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        cur_typed <= typed;
        cur_want  <= want;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic wait_owed_clear();
        req_valid <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        deq_pkg::deq_rsp_t want;
        if (rst_n)
        begin
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch("unexpected result (status)", 32'(rsp.status), '0);
                end
                else
                begin
                    want = owed_results[0];
                    owed_results.delete(0);
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.read_word !== want.read_word)
                        report_mismatch("read_word", rsp.read_word, want.read_word);
                    if (rsp.front_word !== want.front_word)
                        report_mismatch("front_word", rsp.front_word, want.front_word);
                    if (rsp.back_word !== want.back_word)
                        report_mismatch("back_word", rsp.back_word, want.back_word);
                    if (rsp.count !== want.count)
                        report_mismatch("count", 32'(rsp.count), 32'(want.count));
                end
            end
            if (req_valid && req_ready)
            begin
                want = advance_deque(req);
                if (cur_typed)
                begin
                    want = cur_want;
                end
                owed_results.insert(owed_results.size(), want);
            end
        end
    end

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ready <= quiet_stretch || ($urandom_range(99) >= 20);
        end
    end

    initial
    begin
        deq_pkg::deq_rsp_t none;
        load_phase_t       phase;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        cur_typed     = 1'b0;
        cur_want      = '0;
        quiet_stretch = 1'b0;
        none          = '0;

        add_row(deq_pkg::OP_POP_FRONT, 32'sd0, 8'd0, 1'b1,
                rsp_of(deq_pkg::STATUS_EMPTY, 0, 0, 0, 9'd0));
        add_row(deq_pkg::OP_POP_BACK, 32'sd0, 8'd0, 1'b1,
                rsp_of(deq_pkg::STATUS_EMPTY, 0, 0, 0, 9'd0));
        add_row(deq_pkg::OP_READ, 32'sd0, 8'd0, 1'b1,
                rsp_of(deq_pkg::STATUS_RANGE, 0, 0, 0, 9'd0));
        add_row(deq_pkg::OP_READ, -32'sd1, 8'd255, 1'b1,
                rsp_of(deq_pkg::STATUS_RANGE, 0, 0, 0, 9'd0));
        add_row(OP_UNUSED_5, -32'sd1, 8'd255, 1'b1,
                rsp_of(deq_pkg::STATUS_DONE, 0, 0, 0, 9'd0));
        add_row(deq_pkg::OP_PUSH_FRONT, WORD_MAX, 8'd0, 1'b1,
                rsp_of(deq_pkg::STATUS_DONE, 0, WORD_MAX, WORD_MAX, 9'd1));
        add_row(deq_pkg::OP_PUSH_BACK, WORD_MIN, 8'd255, 1'b1,
                rsp_of(deq_pkg::STATUS_DONE, 0, WORD_MAX, WORD_MIN, 9'd2));
        add_row(deq_pkg::OP_READ, 32'sd0, 8'd0, 1'b1,
                rsp_of(deq_pkg::STATUS_DONE, WORD_MAX, WORD_MAX, WORD_MIN, 9'd2));
        add_row(deq_pkg::OP_READ, 32'sd0, 8'd1, 1'b1,
                rsp_of(deq_pkg::STATUS_DONE, WORD_MIN, WORD_MAX, WORD_MIN, 9'd2));
        add_row(deq_pkg::OP_READ, 32'sd0, 8'd2, 1'b1,
                rsp_of(deq_pkg::STATUS_RANGE, 0, WORD_MAX, WORD_MIN, 9'd2));
        add_row(OP_UNUSED_6, 32'sh5A5A_5A5A, 8'd1, 1'b1,
                rsp_of(deq_pkg::STATUS_DONE, 0, WORD_MAX, WORD_MIN, 9'd2));
        add_row(OP_UNUSED_7, WORD_MAX, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_PUSH_FRONT, -32'sd1, 8'd0, 1'b1,
                rsp_of(deq_pkg::STATUS_DONE, 0, -1, WORD_MIN, 9'd3));
        add_row(deq_pkg::OP_PUSH_BACK, 32'sd0, 8'd0, 1'b1,
                rsp_of(deq_pkg::STATUS_DONE, 0, -1, 0, 9'd4));
        add_row(deq_pkg::OP_READ, 32'sd0, 8'd255, 1'b0, none);
        add_row(deq_pkg::OP_POP_FRONT, 32'sd0, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_READ, 32'sd0, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_POP_BACK, 32'sd0, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_POP_BACK, 32'sd0, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_POP_FRONT, 32'sd0, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_POP_FRONT, 32'sd0, 8'd0, 1'b1,
                rsp_of(deq_pkg::STATUS_EMPTY, 0, 0, 0, 9'd0));
        add_row(deq_pkg::OP_PUSH_BACK, 32'sd1, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_POP_FRONT, 32'sd0, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_PUSH_FRONT, 32'sh1234_5678, 8'd0, 1'b0, none);
        add_row(deq_pkg::OP_READ, 32'sd0, 8'd0, 1'b0, none);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fork
            begin
                foreach (directed_rows[i])
                begin
                    send_item(directed_rows[i].item, directed_rows[i].typed,
                              directed_rows[i].want);
                end
                wait_owed_clear();
                for (int n = 0; n < RANDOM_ITEMS; n++)
                begin
                    if (n < 330)
                        phase = PH_FILL;
                    else if (n < 660)
                        phase = PH_DRAIN;
                    else if (n < 790)
                        phase = PH_MIX;
                    else if (n < 1120)
                        phase = PH_FILL;
                    else
                        phase = PH_DRAIN;
                    // Hold off the sender until every owed result is back
                    if (n == 660)
                    begin
                        wait_owed_clear();
                    end
                    quiet_stretch <= (n >= 790 && n < 1000);
                    send_item(random_item(phase), 1'b0, none);
                end
                quiet_stretch <= 1'b0;
                wait_owed_clear();
                repeat (SETTLE_CYCLES) @(negedge clk);
            end
            wait (idle_cycles >= WATCHDOG_LIMIT);
        join_any

        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results owed",
                     idle_cycles, owed_results.size());
        end
        if (idle_cycles < WATCHDOG_LIMIT && mismatches == 0 && owed_results.size() == 0)
        begin
            $display("double_ended_queue_top test passed");
        end
        else
        begin
            $display("double_ended_queue_top test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/deq_pkg.sv
hdl/double_ended_queue_top.sv
test/double_ended_queue_top_tb.sv
